FILE: hdl/ps2mk_pkg.sv
// ----------------------------------------------------------------------------
// ps2mk_pkg: shared types and tables for the scancode to matrix translator
// Holds the result type, the table entry type, the protocol codes and the
// normal and extended scancode lookup functions.
// ----------------------------------------------------------------------------
package ps2mk_pkg;

	localparam logic [7:0] CodeExtended  = 8'hE0;
	localparam logic [7:0] CodeRestore   = 8'h12;
	localparam logic [7:0] CodeShiftLock = 8'h58;
	localparam logic [7:0] BreakPrefixRst = 8'h0F;
	localparam logic [1:0] SkipAfterRestore = 2'd2;

	typedef struct packed {
		logic       has;
		logic       shf;
		logic [6:0] code;
	} map_entry_t;

	typedef struct packed {
		logic [6:0] matrix_code;
		logic       released;
		logic       force_shift;
		logic       restore_event;
		logic       shift_lock_on;
	} key_t;

	typedef struct packed {
		logic emit;
		key_t key;
	} decode_res_t;

	function automatic map_entry_t mk(input logic [6:0] c);
		mk = '{has: 1'b1, shf: 1'b0, code: c};
	endfunction

	function automatic map_entry_t mks(input logic [6:0] c);
		mks = '{has: 1'b1, shf: 1'b1, code: c};
	endfunction

	function automatic map_entry_t normal_lookup(input logic [7:0] sc);
		map_entry_t e;
		e = '0;
		case (sc)
			8'h1C: e = mk(7'h12);
			8'h32: e = mk(7'h34);
			8'h21: e = mk(7'h24);
			8'h23: e = mk(7'h22);
			8'h24: e = mk(7'h16);
			8'h2B: e = mk(7'h25);
			8'h34: e = mk(7'h32);
			8'h33: e = mk(7'h35);
			8'h43: e = mk(7'h41);
			8'h3B: e = mk(7'h42);
			8'h42: e = mk(7'h45);
			8'h4B: e = mk(7'h52);
			8'h3A: e = mk(7'h44);
			8'h31: e = mk(7'h47);
			8'h44: e = mk(7'h46);
			8'h4D: e = mk(7'h51);
			8'h15: e = mk(7'h76);
			8'h2D: e = mk(7'h21);
			8'h1B: e = mk(7'h15);
			8'h2C: e = mk(7'h26);
			8'h3C: e = mk(7'h36);
			8'h2A: e = mk(7'h37);
			8'h1D: e = mk(7'h11);
			8'h22: e = mk(7'h27);
			8'h1A: e = mk(7'h31);
			8'h35: e = mk(7'h14);
			8'h45: e = mk(7'h43);
			8'h16: e = mk(7'h70);
			8'h1E: e = mk(7'h73);
			8'h26: e = mk(7'h10);
			8'h25: e = mk(7'h13);
			8'h2E: e = mk(7'h20);
			8'h36: e = mk(7'h23);
			8'h3D: e = mk(7'h30);
			8'h3E: e = mk(7'h33);
			8'h46: e = mk(7'h40);
			8'h4E: e = mk(7'h53);
			8'h55: e = mk(7'h65);
			8'h66: e = mk(7'h00);
			8'h0E: e = mk(7'h71);
			8'h5A: e = mk(7'h01);
			8'h76: e = mk(7'h77);
			8'h54: e = mk(7'h56);
			8'h5B: e = mk(7'h61);
			8'h4C: e = mk(7'h55);
			8'h52: e = mk(7'h62);
			8'h41: e = mk(7'h57);
			8'h49: e = mk(7'h54);
			8'h4A: e = mk(7'h67);
			8'h05: e = mk(7'h04);
			8'h06: e = mks(7'h04);
			8'h04: e = mk(7'h05);
			8'h0C: e = mks(7'h05);
			8'h03: e = mk(7'h06);
			8'h0B: e = mks(7'h06);
			8'h38: e = mk(7'h03);
			8'h0A: e = mks(7'h03);
			8'h11: e = mk(7'h75);
			8'h01: e = mk(7'h60);
			8'h09: e = mk(7'h50);
			8'h29: e = mk(7'h74);
			8'h12: e = mk(7'h17);
			8'h59: e = mk(7'h64);
			8'h14: e = mk(7'h72);
			8'h0D: e = mk(7'h72);
			8'h00: e = mk(7'h66);
			default: e = '0;
		endcase
		return e;
	endfunction

	function automatic map_entry_t extended_lookup(input logic [7:0] sc);
		map_entry_t e;
		e = '0;
		case (sc)
			8'h6C: e = mk(7'h63);
			8'h75: e = mks(7'h07);
			8'h6B: e = mks(7'h02);
			8'h72: e = mk(7'h07);
			8'h74: e = mk(7'h02);
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

FILE: hdl/ps2mk_code_if.sv
// ----------------------------------------------------------------------------
// ps2mk_code_if: scancode byte channel
// Carries one received scancode byte per beat with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ps2mk_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] scancode;

	modport source (output valid, output scancode, input ready);
	modport sink (input valid, input scancode, output ready);
endinterface

FILE: hdl/ps2mk_key_if.sv
// ----------------------------------------------------------------------------
// ps2mk_key_if: matrix key event channel
// Carries one translated key or restore event per beat.
// ----------------------------------------------------------------------------
interface ps2mk_key_if;
	logic       valid;
	logic       ready;
	logic [6:0] matrix_code;
	logic       released;
	logic       force_shift;
	logic       restore_event;
	logic       shift_lock_on;

	modport source (output valid, output matrix_code, output released, output force_shift,
		output restore_event, output shift_lock_on, input ready);
	modport sink (input valid, input matrix_code, input released, input force_shift,
		input restore_event, input shift_lock_on, output ready);
endinterface

FILE: hdl/ps2mk_decode.sv
// ----------------------------------------------------------------------------
// ps2mk_decode: prefix tracking and table lookup
// Holds the sequence state and shift lock, decodes one byte per advance and
// reports whether the byte produces a key or restore event.
// ----------------------------------------------------------------------------
module ps2mk_decode import ps2mk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic [7:0]  code,
	input  logic [7:0]  break_prefix,
	output decode_res_t res
);

	logic       ext_q, rel_q, lock_q;
	logic [1:0] skip_q;
	logic       ext_d, rel_d, lock_d;
	logic [1:0] skip_d;
	map_entry_t entry;

	always_comb begin
		ext_d  = ext_q;
		rel_d  = rel_q;
		lock_d = lock_q;
		skip_d = skip_q;
		res    = '0;
		res.key.shift_lock_on = lock_q;
		entry  = ext_q ? extended_lookup(code) : normal_lookup(code);
		if (skip_q != 2'd0) begin
			skip_d = skip_q - 2'd1;
		end else if (!ext_q && !rel_q && code == CodeExtended) begin
			ext_d = 1'b1;
		end else if (!rel_q && code == break_prefix) begin
			rel_d = 1'b1;
		end else begin
			ext_d = 1'b0;
			rel_d = 1'b0;
			if (ext_q && code == CodeRestore) begin
				if (rel_q) begin
					skip_d = SkipAfterRestore;
				end else begin
					res.emit = 1'b1;
					res.key.restore_event = 1'b1;
				end
			end else if (!ext_q && code == CodeShiftLock) begin
				if (!rel_q) begin
					lock_d = ~lock_q;
				end
			end else if (entry.has) begin
				res.emit = 1'b1;
				res.key.matrix_code = entry.code;
				res.key.released = rel_q;
				res.key.force_shift = entry.shf;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q  <= 1'b0;
			rel_q  <= 1'b0;
			lock_q <= 1'b0;
			skip_q <= 2'd0;
		end else if (advance) begin
			ext_q  <= ext_d;
			rel_q  <= rel_d;
			lock_q <= lock_d;
			skip_q <= skip_d;
		end
	end

endmodule

FILE: hdl/ps2mk_out_reg.sv
// ----------------------------------------------------------------------------
// ps2mk_out_reg: result register
// Holds one decoded event until the sink takes it and tells the stage in
// front whether a new byte may be decoded this cycle.
// ----------------------------------------------------------------------------
module ps2mk_out_reg import ps2mk_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  decode_res_t     res,
	output logic            advance,
	ps2mk_key_if.source     key
);

	logic valid_q;
	key_t key_q;

	assign advance = in_valid && (!valid_q || key.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res.emit;
		end else if (key.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			key_q <= res.key;
		end
	end

	assign key.valid         = valid_q;
	assign key.matrix_code   = key_q.matrix_code;
	assign key.released      = key_q.released;
	assign key.force_shift   = key_q.force_shift;
	assign key.restore_event = key_q.restore_event;
	assign key.shift_lock_on = key_q.shift_lock_on;

endmodule

FILE: hdl/ps2_scancode_to_matrix_key.sv
// ----------------------------------------------------------------------------
// ps2_scancode_to_matrix_key: keyboard scancode to 8x8 matrix translator
// Turns set 2 scancode sequences into matrix key and restore events.
// ----------------------------------------------------------------------------
//  Channel       Direction  Beat contents
//  code          in         scancode
//  key           out        matrix_code, released, force_shift,
//                           restore_event, shift_lock_on
//  break_prefix  in         write enable and byte value
//
// A byte is registered on input and decoded from that register into the result
// register; its event becomes valid when the result register loads it.
// One byte is accepted per cycle while input ready stays high; the decode
// register and the result register set that rate. Reset clears all sequence
// state and shift lock. When both registers hold a beat and the result is not
// taken, input ready drops.
// ----------------------------------------------------------------------------
module ps2_scancode_to_matrix_key import ps2mk_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           break_prefix_we,
	input  logic [7:0]     break_prefix_wdata,
	ps2mk_code_if.sink     code,
	ps2mk_key_if.source    key
);

	logic        valid_s1;
	logic [7:0]  code_s1;
	logic [7:0]  break_prefix_q;
	logic        advance;
	decode_res_t res;

	assign code.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			break_prefix_q <= BreakPrefixRst;
		end else begin
			if (code.ready) begin
				valid_s1 <= code.valid;
			end
			if (break_prefix_we) begin
				break_prefix_q <= break_prefix_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (code.valid && code.ready) begin
			code_s1 <= code.scancode;
		end
	end

	ps2mk_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.code         (code_s1),
		.break_prefix (break_prefix_q),
		.res          (res)
	);

	ps2mk_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.res      (res),
		.advance  (advance),
		.key      (key)
	);

endmodule
